@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the cylinder push-out unit.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define CPO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true out of reset.
`define CPO_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ hw/rtl/cyl_push_pkg.sv @@
// Types, stage map and step functions for the cylinder push-out pipeline.
// No dependencies.
package cyl_push_pkg;

    localparam int FRAC_BITS = 16;
    localparam logic [30:0] KNOCK_RESET = 31'(5 << FRAC_BITS);

    // Stage map (two sqrt / divide steps per stage)
    localparam int SQRT_STAGES = 16;
    localparam int DIV_STAGES  = 16;
    localparam int ST_SQRT0    = 4;
    localparam int ST_MUL      = ST_SQRT0 + SQRT_STAGES;
    localparam int ST_DIV0     = ST_MUL + 2;
    localparam int ST_SUM      = ST_DIV0 + DIV_STAGES;
    localparam int ST_OUT      = ST_SUM + 1;
    localparam int PIPE_DEPTH  = ST_OUT + 1;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] bz;
        logic signed [31:0] by;
    } base_t;

    typedef struct packed {
        logic               hit;
        logic               zero;
        logic               sx;
        logic               sz;
        logic [31:0]        mx;
        logic [31:0]        mz;
        logic [31:0]        len;
        logic signed [31:0] base_x;
        logic signed [31:0] base_z;
        logic signed [31:0] b_y;
    } pay_t;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] r;
    } sqrt_st_t;

    // One step of the digit-by-digit integer square root; idx 0..31
    function automatic sqrt_st_t sqrt_step(sqrt_st_t s, int unsigned idx);
        logic [63:0] bitv;
        logic [63:0] t;
        sqrt_st_t    o;
        bitv = 64'd1 << 6'(62 - 2 * idx);
        t    = s.r + bitv;
        if (s.x >= t)
        begin
            o.x = s.x - t;
            o.r = (s.r >> 1) + bitv;
        end
        else
        begin
            o.x = s.x;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    // One restoring divide step: {rem, dividend/quotient}
    function automatic logic [63:0] div_step(logic [63:0] s, logic [31:0] d);
        logic [32:0] t;
        logic        ge;
        logic [31:0] hi;
        t  = s[63:31];
        ge = (t >= {1'b0, d});
        hi = ge ? 32'(t - {1'b0, d}) : t[31:0];
        return {hi, s[30:0], ge};
    endfunction

endpackage

@@ hw/rtl/cylinder_cylinder_pushout_unit.sv @@
// Pipeline: 40 register stages, from the input differences to the saturated output register.
// Throughput: one pair per cycle without out_stall; a stage holds only while the next is full
// and blocked, so bubbles collapse and inputs keep flowing behind a waiting result.
// Speed set by the 32-step square root and 32-step divide, two steps per stage.
// Reset (rst_n low, async): all stage valids clear, knockback returns to 5.0.
// Depends on cyl_push_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cylinder_cylinder_pushout_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [30:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic [30:0]        a_radius,
    input  logic [30:0]        a_height,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic [30:0]        b_radius,
    input  logic [30:0]        b_height,
    input  logic               slam_mode,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic signed [31:0] new_b_x,
    output logic signed [31:0] new_b_y,
    output logic signed [31:0] new_b_z
);
    import cyl_push_pkg::*;

    // ---------------- configuration ----------------
    logic [30:0] knock_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            knock_reg <= KNOCK_RESET;
        else if (cfg_wr_en)
            knock_reg <= cfg_wr_data;
    end

    // ---------------- flow control ----------------
    // A stage loads when it is empty or the stage after it loads.
    logic [PIPE_DEPTH-1:0] v_reg;
    logic [PIPE_DEPTH-1:0] en;

    always_comb
    begin
        en[PIPE_DEPTH-1] = !v_reg[PIPE_DEPTH-1] || !out_stall;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < PIPE_DEPTH; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // ---------------- stage 0: differences, vertical test ----------------
    logic signed [32:0] s0_vx_reg, s0_vz_reg;
    logic [31:0]        s0_range_reg;
    logic               s0_vmiss_reg, s0_slam_reg;
    base_t              s0_base_reg;

    logic signed [33:0] a_top, b_top, a_y34, b_y34;
    logic               vmiss_next;

    always_comb
    begin
        a_y34      = 34'(a_y);
        b_y34      = 34'(b_y);
        a_top      = a_y34 + $signed({3'b000, a_height});
        b_top      = b_y34 + $signed({3'b000, b_height});
        vmiss_next = !slam_mode && ((a_y34 > b_top) || (a_top < b_y34));
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_vx_reg      <= 33'(b_x) - 33'(a_x);
            s0_vz_reg      <= 33'(b_z) - 33'(a_z);
            s0_range_reg   <= {1'b0, a_radius} + {1'b0, b_radius};
            s0_vmiss_reg   <= vmiss_next;
            s0_slam_reg    <= slam_mode;
            s0_base_reg    <= '{ax: a_x, az: a_z, bx: b_x, bz: b_z, by: b_y};
        end
    end

    // ---------------- stage 1: magnitudes, box reject ----------------
    logic [31:0] s1_mx_reg, s1_mz_reg, s1_range_reg;
    logic        s1_sx_reg, s1_sz_reg, s1_near_reg, s1_slam_reg;
    base_t       s1_base_reg;
    logic [31:0] mx_next, mz_next;

    always_comb
    begin
        mx_next = s0_vx_reg[32] ? 32'(-s0_vx_reg) : s0_vx_reg[31:0];
        mz_next = s0_vz_reg[32] ? 32'(-s0_vz_reg) : s0_vz_reg[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_mx_reg    <= mx_next;
            s1_mz_reg    <= mz_next;
            s1_sx_reg    <= s0_vx_reg[32];
            s1_sz_reg    <= s0_vz_reg[32];
            s1_near_reg  <= !s0_vmiss_reg && (mx_next <= s0_range_reg)
                            && (mz_next <= s0_range_reg);
            s1_range_reg <= s0_range_reg;
            s1_slam_reg  <= s0_slam_reg;
            s1_base_reg  <= s0_base_reg;
        end
    end

    // ---------------- stage 2: squares ----------------
    logic [63:0] s2_px_reg, s2_pz_reg, s2_rr_reg;
    logic [31:0] s2_mx_reg, s2_mz_reg, s2_range_reg;
    logic        s2_sx_reg, s2_sz_reg, s2_near_reg, s2_slam_reg;
    base_t       s2_base_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_px_reg    <= 64'(s1_mx_reg) * 64'(s1_mx_reg);
            s2_pz_reg    <= 64'(s1_mz_reg) * 64'(s1_mz_reg);
            s2_rr_reg    <= 64'(s1_range_reg) * 64'(s1_range_reg);
            s2_mx_reg    <= s1_mx_reg;
            s2_mz_reg    <= s1_mz_reg;
            s2_range_reg <= s1_range_reg;
            s2_sx_reg    <= s1_sx_reg;
            s2_sz_reg    <= s1_sz_reg;
            s2_near_reg  <= s1_near_reg;
            s2_slam_reg  <= s1_slam_reg;
            s2_base_reg  <= s1_base_reg;
        end
    end

    // ---------------- stage 3: radial test, push setup ----------------
    sqrt_st_t    s3_st_reg;
    pay_t        s3_pay_reg;
    logic [64:0] sq_sum;
    logic        hit3;
    pay_t        pay3_next;

    always_comb
    begin
        sq_sum = {1'b0, s2_px_reg} + {1'b0, s2_pz_reg};
        hit3   = s2_near_reg && (sq_sum <= {1'b0, s2_rr_reg});
        pay3_next.hit    = hit3;
        pay3_next.zero   = (sq_sum == '0);
        pay3_next.sx     = s2_sx_reg;
        pay3_next.sz     = s2_sz_reg;
        pay3_next.mx     = s2_mx_reg;
        pay3_next.mz     = s2_mz_reg;
        pay3_next.len    = s2_slam_reg ? {1'b0, knock_reg} : s2_range_reg;
        // normal hit lands on A's rim; slam or miss starts from B
        pay3_next.base_x = (hit3 && !s2_slam_reg) ? s2_base_reg.ax : s2_base_reg.bx;
        pay3_next.base_z = (hit3 && !s2_slam_reg) ? s2_base_reg.az : s2_base_reg.bz;
        pay3_next.b_y    = s2_base_reg.by;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_st_reg  <= '{x: sq_sum[63:0], r: 64'd0};
            s3_pay_reg <= pay3_next;
        end
    end

    // ---------------- square root, two steps per stage ----------------
    sqrt_st_t sq_reg [SQRT_STAGES];
    pay_t     sp_reg [SQRT_STAGES];

    for (genvar s = 0; s < SQRT_STAGES; s++)
    begin : g_sqrt
        sqrt_st_t in_st, mid_st, st_next;
        pay_t     in_p;

        if (s == 0)
        begin : g_first
            assign in_st = s3_st_reg;
            assign in_p  = s3_pay_reg;
        end
        else
        begin : g_rest
            assign in_st = sq_reg[s-1];
            assign in_p  = sp_reg[s-1];
        end

        assign mid_st  = sqrt_step(in_st, 2 * s);
        assign st_next = sqrt_step(mid_st, 2 * s + 1);

        always_ff @(posedge clk)
        begin
            if (en[ST_SQRT0+s])
            begin
                sq_reg[s] <= st_next;
                sp_reg[s] <= in_p;
            end
        end
    end

    // ---------------- scale: |v| * len ----------------
    logic [31:0] s20_dist_reg;
    logic [63:0] s20_px_reg, s20_pz_reg;
    pay_t        s20_pay_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_MUL])
        begin
            s20_dist_reg <= sq_reg[SQRT_STAGES-1].r[31:0];
            s20_px_reg   <= 64'(sp_reg[SQRT_STAGES-1].mx) * 64'(sp_reg[SQRT_STAGES-1].len);
            s20_pz_reg   <= 64'(sp_reg[SQRT_STAGES-1].mz) * 64'(sp_reg[SQRT_STAGES-1].len);
            s20_pay_reg  <= sp_reg[SQRT_STAGES-1];
        end
    end

    // ---------------- rounding bias; dividend high half is below dist ----------------
    logic [63:0] s21_nx_reg, s21_nz_reg;
    logic [31:0] s21_dist_reg;
    pay_t        s21_pay_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_MUL+1])
        begin
            s21_nx_reg   <= s20_px_reg + 64'(s20_dist_reg >> 1);
            s21_nz_reg   <= s20_pz_reg + 64'(s20_dist_reg >> 1);
            s21_dist_reg <= s20_dist_reg;
            s21_pay_reg  <= s20_pay_reg;
        end
    end

    // ---------------- divide, two steps per stage, x and z lanes ----------------
    logic [63:0] dx_reg [DIV_STAGES];
    logic [63:0] dz_reg [DIV_STAGES];
    logic [31:0] dd_reg [DIV_STAGES];
    pay_t        dp_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        logic [63:0] in_x, in_z;
        logic [31:0] in_d;
        pay_t        in_p;

        if (s == 0)
        begin : g_first
            assign in_x = s21_nx_reg;
            assign in_z = s21_nz_reg;
            assign in_d = s21_dist_reg;
            assign in_p = s21_pay_reg;
        end
        else
        begin : g_rest
            assign in_x = dx_reg[s-1];
            assign in_z = dz_reg[s-1];
            assign in_d = dd_reg[s-1];
            assign in_p = dp_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (en[ST_DIV0+s])
            begin
                dx_reg[s] <= div_step(div_step(in_x, in_d), in_d);
                dz_reg[s] <= div_step(div_step(in_z, in_d), in_d);
                dd_reg[s] <= in_d;
                dp_reg[s] <= in_p;
            end
        end
    end

    // ---------------- apply signed offsets ----------------
    logic signed [33:0] s38_x_reg, s38_z_reg;
    logic               s38_hit_reg;
    logic signed [31:0] s38_y_reg;

    pay_t               pd;
    logic [31:0]        ox, oz;
    logic signed [33:0] bx34, bz34, ox34, oz34;

    always_comb
    begin
        pd = dp_reg[DIV_STAGES-1];
        if (!pd.hit)
        begin
            ox = '0;
            oz = '0;
        end
        else if (pd.zero)
        begin
            // coincident centers: push along +x
            ox = pd.len;
            oz = '0;
        end
        else
        begin
            ox = dx_reg[DIV_STAGES-1][31:0];
            oz = dz_reg[DIV_STAGES-1][31:0];
        end
        bx34 = 34'(pd.base_x);
        bz34 = 34'(pd.base_z);
        ox34 = $signed({2'b00, ox});
        oz34 = $signed({2'b00, oz});
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            s38_x_reg   <= pd.sx ? bx34 - ox34 : bx34 + ox34;
            s38_z_reg   <= pd.sz ? bz34 - oz34 : bz34 + oz34;
            s38_hit_reg <= pd.hit;
            s38_y_reg   <= pd.b_y;
        end
    end

    // ---------------- saturate into the output register ----------------
    logic               hit_reg;
    logic signed [31:0] new_b_x_reg, new_b_y_reg, new_b_z_reg;
    logic signed [31:0] sat_x_next, sat_z_next;

    always_comb
    begin
        if (s38_x_reg[33:31] == 3'b000 || s38_x_reg[33:31] == 3'b111)
            sat_x_next = s38_x_reg[31:0];
        else
            sat_x_next = s38_x_reg[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        if (s38_z_reg[33:31] == 3'b000 || s38_z_reg[33:31] == 3'b111)
            sat_z_next = s38_z_reg[31:0];
        else
            sat_z_next = s38_z_reg[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            hit_reg     <= s38_hit_reg;
            new_b_x_reg <= sat_x_next;
            new_b_y_reg <= s38_y_reg;
            new_b_z_reg <= sat_z_next;
        end
    end

    assign hit     = hit_reg;
    assign new_b_x = new_b_x_reg;
    assign new_b_y = new_b_y_reg;
    assign new_b_z = new_b_z_reg;

    // ---------------- assertions ----------------
    `CPO_ASSERT(a_zero_root, v_reg[ST_MUL] && s20_pay_reg.zero |-> s20_dist_reg == '0, "zero distance with nonzero root")
    `CPO_NEVER(a_quot_bound, v_reg[ST_SUM-1] && pd.hit && !pd.zero && (dx_reg[DIV_STAGES-1][31:0] > pd.len), "x offset exceeds push length")
    `CPO_ASSERT(a_sum_hold, v_reg[ST_SUM] && !en[ST_SUM] |=> v_reg[ST_SUM] && $stable(s38_x_reg) && $stable(s38_z_reg), "blocked stage lost its contents")

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for cylinder_cylinder_pushout_unit.
// Depends on cyl_push_pkg and the unit's RTL; an in-bench predictor scores every transfer.
module testbench;
    import cyl_push_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One cylinder pair as offered on the input channel
    typedef struct {
        logic signed [31:0] ax, ay, az, bx, by, bz;
        logic [30:0]        ar, ah, br, bh;
        logic               slam;
    } pair_t;

    // Resolved position of B as the unit should report it
    typedef struct {
        logic               hit;
        logic signed [31:0] x, y, z;
    } pushout_t;

    // Scoreboard: predicts the push-out of each accepted pair and checks results in order
    class pushout_board;
        logic [30:0] knock;
        pushout_t    pending[$];
        int          errors;

        function new();
            knock  = KNOCK_RESET;
            errors = 0;
        endfunction

        static function logic [63:0] floor_sqrt(logic [63:0] v);
            logic [63:0] res, b;
            res = 0;
            b   = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        // Rounded |v| * len / root, sign of v restored
        static function longint push_offset(longint v, logic [63:0] len, logic [63:0] root);
            logic [63:0] mag, q;
            mag = (v < 0) ? 64'(-v) : 64'(v);
            q   = (mag * len + root / 2) / root;
            return (v < 0) ? -longint'(q) : longint'(q);
        endfunction

        static function logic signed [31:0] clamp32(longint v);
            if (v > 64'sd2147483647)
                return 32'sh7fffffff;
            if (v < -64'sd2147483648)
                return 32'sh80000000;
            return v[31:0];
        endfunction

        function void note_transfer(pair_t p);
            longint      ax, ay, az, bx, by, bz, ah, bh, vx, vz, nx, nz, ox, oz;
            logic [63:0] range, mx, mz, px, pz, sq, len;
            pushout_t    e;
            ax = p.ax; ay = p.ay; az = p.az;
            bx = p.bx; by = p.by; bz = p.bz;
            ah = longint'({1'b0, p.ah});
            bh = longint'({1'b0, p.bh});
            range = {33'd0, p.ar} + {33'd0, p.br};
            vx = bx - ax;
            vz = bz - az;
            mx = (vx < 0) ? 64'(-vx) : 64'(vx);
            mz = (vz < 0) ? 64'(-vz) : 64'(vz);
            sq = 0;
            e.hit = 1'b1;
            nx = bx;
            nz = bz;
            // vertical spans only matter outside slam mode
            if (!p.slam && (ay > by + bh || ay + ah < by))
                e.hit = 1'b0;
            if (e.hit && (mx > range || mz > range))
                e.hit = 1'b0;
            if (e.hit)
            begin
                px = mx * mx;
                pz = mz * mz;
                sq = px + pz;
                if (sq < px || sq > range * range)
                    e.hit = 1'b0;
            end
            if (e.hit)
            begin
                len = p.slam ? {33'd0, knock} : range;
                if (sq == 0)
                begin
                    // coincident centers push along +x
                    ox = longint'(len);
                    oz = 0;
                end
                else
                begin
                    ox = push_offset(vx, len, floor_sqrt(sq));
                    oz = push_offset(vz, len, floor_sqrt(sq));
                end
                nx = (p.slam ? bx : ax) + ox;
                nz = (p.slam ? bz : az) + oz;
            end
            e.x = clamp32(nx);
            e.z = clamp32(nz);
            e.y = p.by;
            pending.push_back(e);
        endfunction

        function void check_result(logic h, logic signed [31:0] x, logic signed [31:0] y,
                                   logic signed [31:0] z);
            pushout_t e;
            if (pending.size() == 0)
            begin
                $error("result with no pair outstanding: hit %0b x %0d z %0d", h, x, z);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (h !== e.hit)
            begin
                $error("hit: expected %0b, got %0b", e.hit, h);
                errors++;
            end
            if (x !== e.x)
            begin
                $error("new_b_x: expected %0d, got %0d", e.x, x);
                errors++;
            end
            if (y !== e.y)
            begin
                $error("new_b_y: expected %0d, got %0d", e.y, y);
                errors++;
            end
            if (z !== e.z)
            begin
                $error("new_b_z: expected %0d, got %0d", e.z, z);
                errors++;
            end
        endfunction
    endclass

    localparam int LATENCY     = PIPE_DEPTH + 10;
    localparam int CYCLE_LIMIT = 400000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [30:0]        cfg_wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] a_x = '0, a_y = '0, a_z = '0, b_x = '0, b_y = '0, b_z = '0;
    logic [30:0]        a_radius = '0, a_height = '0, b_radius = '0, b_height = '0;
    logic               slam_mode = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               hit;
    logic signed [31:0] new_b_x, new_b_y, new_b_z;

    pushout_board board = new();
    int  cycles = 0;
    int  hold_requests = 0;   // bumped by the stimulus to ask the receiver for a long hold
    bit  burst = 0;           // sender offers back to back while set
    bit  calm = 0;            // receiver draws no random stalls while set

    cylinder_cylinder_pushout_unit DUT (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random stall per result, plus one long hold on request
    int stall_left = 0;
    int holds_seen = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_requests != holds_seen)
            begin
                holds_seen = hold_requests;
                stall_left = 300;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                // a transfer happens at this edge: draw the stall ahead of the next result
                if (out_valid && !out_stall && !calm)
                    stall_left = $urandom_range(0, 10);
            end
        end
    end

    // Result monitor: a transfer is valid high with stall low at the edge
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result(hit, new_b_x, new_b_y, new_b_z);

    task automatic send_pair(pair_t p);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        a_x <= p.ax; a_y <= p.ay; a_z <= p.az;
        a_radius <= p.ar; a_height <= p.ah;
        b_x <= p.bx; b_y <= p.by; b_z <= p.bz;
        b_radius <= p.br; b_height <= p.bh;
        slam_mode <= p.slam;
        do
            @(posedge clk);
        while (in_stall);
        board.note_transfer(p);
    endtask

    // Wait until every result is back and the pipe is empty
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic set_knockback(logic [30:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.knock = v;
    endtask

    function automatic pair_t full_random();
        pair_t p;
        p.ax = $urandom; p.ay = $urandom; p.az = $urandom;
        p.bx = $urandom; p.by = $urandom; p.bz = $urandom;
        p.ar = 31'($urandom); p.ah = 31'($urandom);
        p.br = 31'($urandom); p.bh = 31'($urandom);
        p.slam = 1'($urandom_range(0, 1));
        return p;
    endfunction

    // Pair whose B lies around A, so most of these reach the push-out math
    function automatic pair_t near_pair();
        pair_t  p;
        int     s;
        longint lim, hlim;
        p = full_random();
        s = $urandom_range(2, 30);
        p.ar = 31'($urandom & ((32'd1 << s) - 1));
        p.br = 31'($urandom & ((32'd1 << s) - 1));
        p.ah = 31'($urandom & ((32'd1 << s) - 1));
        p.bh = 31'($urandom & ((32'd1 << s) - 1));
        lim  = longint'({1'b0, p.ar}) + longint'({1'b0, p.br}) + 2;
        hlim = longint'({1'b0, p.ah}) + longint'({1'b0, p.bh}) + 2;
        p.bx = p.ax + 32'(longint'($urandom_range(0, 32'(lim * 3 / 2))) - lim * 3 / 4);
        p.bz = p.az + 32'(longint'($urandom_range(0, 32'(lim * 3 / 2))) - lim * 3 / 4);
        p.by = p.ay + 32'(longint'($urandom_range(0, 32'(hlim))) - hlim / 2);
        return p;
    endfunction

    function automatic pair_t shaped_pair(logic signed [31:0] ax, logic signed [31:0] az,
                                          logic signed [31:0] bx, logic signed [31:0] bz,
                                          logic [30:0] ar, logic [30:0] br, logic slam);
        pair_t p;
        p.ax = ax; p.az = az; p.bx = bx; p.bz = bz;
        p.ar = ar; p.br = br; p.slam = slam;
        p.ay = 0; p.by = 0; p.ah = 31'd65536; p.bh = 31'd65536;
        return p;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                burst = ~burst;
            if ($urandom_range(0, 39) == 0)
                calm = ~calm;
            send_pair(($urandom_range(0, 9) < 7) ? near_pair() : full_random());
        end
        burst = 0;
        calm  = 0;
    endtask

    initial
    begin
        pair_t p;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: coincident centers, normal and slam, with default knockback
        send_pair(shaped_pair(100, 200, 100, 200, 31'd65536, 31'd32768, 1'b0));
        send_pair(shaped_pair(100, 200, 100, 200, 31'd65536, 31'd32768, 1'b1));
        send_pair(shaped_pair(0, 0, 0, 0, 31'd0, 31'd0, 1'b0));
        // Exactly touching rims count as a hit; one unit further is a miss
        send_pair(shaped_pair(0, 0, 3000, 0, 31'd1000, 31'd2000, 1'b0));
        send_pair(shaped_pair(0, 0, 3001, 0, 31'd1000, 31'd2000, 1'b0));
        send_pair(shaped_pair(0, 0, 3, 4, 31'd2, 31'd3, 1'b0));
        send_pair(shaped_pair(0, 0, -1, 0, 31'd5, 31'd5, 1'b1));
        // Vertical miss from above and below; slam ignores it
        p = shaped_pair(0, 0, 10, 10, 31'd100, 31'd100, 1'b0);
        p.by = 32'sd200000;
        send_pair(p);
        p.slam = 1'b1;
        send_pair(p);
        p.slam = 1'b0;
        p.by = -32'sd200000;
        send_pair(p);
        // Saturation toward both limits, mostly with the widest radii
        send_pair(shaped_pair(32'sh7fffff00, 0, 32'sh7fffffff, 0,
                              31'h7fffffff, 31'h7fffffff, 1'b0));
        send_pair(shaped_pair(32'sh80000100, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                              31'h7fffffff, 31'h7fffffff, 1'b0));
        send_pair(shaped_pair(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                              31'h7fffffff, 31'h7fffffff, 1'b0));
        send_pair(shaped_pair(32'sh80000000, 0, 32'sh7fffffff, 0,
                              31'h7fffffff, 31'h7fffffff, 1'b1));
        send_pair(shaped_pair(0, 32'sh7ffffff0, 0, 32'sh7fffffff, 31'd100, 31'd100, 1'b1));
        // Extreme heights and y
        p = full_random();
        p.ay = 32'sh80000000; p.by = 32'sh7fffffff;
        p.ah = 31'h7fffffff; p.bh = 31'h7fffffff;
        p.bx = p.ax; p.bz = p.az;
        send_pair(p);
        random_phase(180);

        // Receiver holds off long while the sender keeps offering back to back
        burst = 1;
        hold_requests++;
        random_phase(80);
        drain();

        set_knockback(31'd0);
        random_phase(140);
        drain();

        set_knockback(31'h7fffffff);
        send_pair(shaped_pair(0, 0, 0, 0, 31'd1, 31'd1, 1'b1));
        send_pair(shaped_pair(0, 0, 7, -7, 31'd10, 31'd10, 1'b1));
        random_phase(140);
        drain();

        set_knockback(31'($urandom_range(1, 32'h00200000)));
        random_phase(200);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
